@@ sv/assert_macros.svh @@
// Assertion macros shared by the level meter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

@@ sv/iqm_pkg.sv @@
// Package: shared constants and types of the I/Q level meter.
package iqm_pkg;
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int COUNT_BITS_DEF  = 24;

    localparam int RAW_BITS    = 12;
    localparam int WINDOW_BITS = 16;
    localparam int RMS_BITS    = 16;
    localparam int PEAK_BITS   = 12;
    localparam int TOTAL_BITS  = 32;

    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 16'd500;
    localparam logic [RAW_BITS-1:0]    CENTRE_RESET = 12'd2048;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_MS    = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CENTRE_COUNT = 1'b1;

    // Item kinds.
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_TICK   = 1'b1;

    // Status of an iterative arithmetic unit.
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;
endpackage

@@ sv/iqm_in_if.sv @@
// Interface: input item channel of the I/Q level meter.
interface iqm_in_if import iqm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                action;
    logic [RAW_BITS-1:0] raw_i;
    logic                i_ok;
    logic [RAW_BITS-1:0] raw_q;
    logic                q_ok;

    modport source (output valid, action, raw_i, i_ok, raw_q, q_ok, input ready);
    modport sink   (input valid, action, raw_i, i_ok, raw_q, q_ok, output ready);
endinterface

@@ sv/iqm_out_if.sv @@
// Interface: report item channel of the I/Q level meter.
interface iqm_out_if import iqm_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [RMS_BITS-1:0]   rms_i_q4;
    logic [PEAK_BITS-1:0]  peak_i;
    logic [RMS_BITS-1:0]   rms_q_q4;
    logic [PEAK_BITS-1:0]  peak_q;
    logic [TOTAL_BITS-1:0] error_total;
    logic [TOTAL_BITS-1:0] rate_hz;

    modport source (output valid, rms_i_q4, peak_i, rms_q_q4, peak_q, error_total, rate_hz,
                    input ready);
    modport sink   (input valid, rms_i_q4, peak_i, rms_q_q4, peak_q, error_total, rate_hz,
                    output ready);
endinterface

@@ sv/iqm_divider.sv @@
// Module: restoring divider, one quotient bit per cycle.
module iqm_divider import iqm_pkg::*; #(
    parameter int DW = 56,
    parameter int VW = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic [DW-1:0] o_quotient,
    output t_unit_stat    o_stat
);
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] r_quo;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_div;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [VW:0] trial;
    logic [VW:0] diff;
    logic        ge;

    // Bring down the next dividend bit and try the subtract.
    always_comb begin
        trial = {r_rem, r_quo[DW-1]};
        diff  = trial - {1'b0, r_div};
        ge    = trial >= {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_quo  <= i_dividend;
                r_div  <= i_divisor;
                r_rem  <= '0;
                r_cnt  <= CW'(DW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_quo <= {r_quo[DW-2:0], ge};
                r_rem <= ge ? diff[VW-1:0] : trial[VW-1:0];
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quotient  = r_quo;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
endmodule

@@ sv/iqm_isqrt.sv @@
// Module: integer square root, one result bit per cycle.
module iqm_isqrt import iqm_pkg::*; #(
    parameter int XW = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [XW-1:0]    i_radicand,
    output logic [XW/2-1:0]  o_root,
    output t_unit_stat       o_stat
);
    localparam int RW = XW / 2;
    localparam int CW = $clog2(RW + 1);

    logic [XW-1:0] r_x;
    logic [RW:0]   r_rem;
    logic [RW-1:0] r_root;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [RW+2:0] rem_sh;
    logic [RW+2:0] trial;
    logic [RW+2:0] rem_sub;
    logic          ge;

    // Bring down two radicand bits and try 4*root+1.
    always_comb begin
        rem_sh  = {r_rem, r_x[XW-1:XW-2]};
        trial   = {1'b0, r_root, 2'b01};
        rem_sub = rem_sh - trial;
        ge      = rem_sh >= trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_x    <= i_radicand;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= CW'(RW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_x    <= {r_x[XW-3:0], 2'b00};
                r_rem  <= ge ? rem_sub[RW:0] : rem_sh[RW:0];
                r_root <= {r_root[RW-2:0], ge};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_root      = r_root;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
endmodule

@@ sv/iq_windowed_rms_peak_meter.sv @@
// Top level: two-channel windowed RMS and peak level meter with sequencer.
// Sample item: accepted, squared, then accumulated before the input is ready again; a tick
// that does not close the window keeps the input ready. Closing tick: three divisions on
// the bit-serial divider (DW = 2*SAMPLE_BITS+COUNT_BITS+8) and two roots on the bit-serial
// square root (RW = SAMPLE_BITS+4), held while the previous report still waits. Reset
// (synchronous, active low) loads window 500 and centre 2048 and clears all sums.
`include "assert_macros.svh"
module iq_windowed_rms_peak_meter import iqm_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    iqm_in_if.sink                    i_in,
    iqm_out_if.source                 o_out
);
    localparam int SB = SAMPLE_BITS;
    localparam int CB = COUNT_BITS;
    localparam int SW = 2 * SB + CB;     // sum of squares
    localparam int DW = SW + 8;          // divider dividend and quotient
    localparam int XW = 2 * SB + 8;      // scaled mean square, bounded by the per-sample max
    localparam int RW = XW / 2;          // root
    localparam logic [CB-1:0] CNT_MAX = {CB{1'b1}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ACC,
        ST_DIV_I,
        ST_DIV_Q,
        ST_DIV_R,
        ST_ROOT_I,
        ST_ROOT_Q,
        ST_OUT
    } t_state;

    t_state r_state;

    // Configuration.
    logic [WINDOW_BITS-1:0] r_window;
    logic [RAW_BITS-1:0]    r_centre;

    // Window state.
    logic [SW-1:0]          r_sum_i, r_sum_q;
    logic [SB-1:0]          r_peak_i, r_peak_q;
    logic [CB-1:0]          r_cnt_i, r_cnt_q;
    logic [TOTAL_BITS-1:0]  r_fail;
    logic [WINDOW_BITS-1:0] r_ms;

    // Per-item working registers.
    logic [SB-1:0]   r_mag_i, r_mag_q;
    logic            r_ok_i, r_ok_q;
    logic [2*SB-1:0] r_sq_i, r_sq_q;

    // Report working registers.
    logic [XW-1:0] r_scaled_i, r_scaled_q;
    logic [DW-1:0] r_rate_q;
    logic [RW-1:0] r_root_i, r_root_q;
    logic          r_issued;

    // Output register.
    logic                  r_out_valid;
    logic [RMS_BITS-1:0]   r_out_rms_i, r_out_rms_q;
    logic [PEAK_BITS-1:0]  r_out_peak_i, r_out_peak_q;
    logic [TOTAL_BITS-1:0] r_out_error, r_out_rate;

    // Shared units.
    logic          div_start, sq_start;
    logic [DW-1:0] div_dividend, div_quotient;
    logic [CB-1:0] div_divisor;
    logic [XW-1:0] sq_radicand;
    logic [RW-1:0] sq_root;
    t_unit_stat    div_stat, sq_stat;

    logic in_fire, out_fire, out_load;
    logic [SB-1:0] samp_i, samp_q, centre;
    logic [SB-1:0] mag_i, mag_q;
    logic [WINDOW_BITS-1:0] n_ms, limit;
    logic [CB+9:0] cnt_x1000;

    // Sequencer phases and window status watched by the checks below.
    logic div_phase, root_phase, peak_lone, report_ok;

    // Reduce a 12-bit reading to SAMPLE_BITS, as the ADC mask does.
    function automatic logic [SB-1:0] to_sample(input logic [RAW_BITS-1:0] raw);
        logic [15:0] wide;
        wide = {4'd0, raw};
        return wide[SB-1:0];
    endfunction

    function automatic logic [SB-1:0] abs_diff(input logic [SB-1:0] a, input logic [SB-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [RMS_BITS-1:0] rms_out(input logic [RW-1:0] root,
                                                    input logic [CB-1:0] cnt);
        logic [31:0] wide;
        wide = 32'(root);
        if (cnt == '0) begin
            return '0;
        end
        return (wide > 32'hFFFF) ? 16'hFFFF : wide[15:0];
    endfunction

    function automatic logic [PEAK_BITS-1:0] peak_out(input logic [SB-1:0] peak);
        logic [31:0] wide;
        wide = 32'(peak);
        return (wide > 32'hFFF) ? 12'hFFF : wide[11:0];
    endfunction

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_fire = r_out_valid && o_out.ready;
    // Load the report once the output register is free or being emptied.
    assign out_load = (r_state == ST_OUT) && (!r_out_valid || out_fire);

    always_comb begin
        samp_i = to_sample(i_in.raw_i);
        samp_q = to_sample(i_in.raw_q);
        centre = to_sample(r_centre);
        mag_i  = abs_diff(samp_i, centre);
        mag_q  = abs_diff(samp_q, centre);
        // Saturate the elapsed count; a zero window acts as one tick.
        n_ms   = (r_ms == 16'hFFFF) ? r_ms : r_ms + 1'b1;
        limit  = (r_window == '0) ? 16'd1 : r_window;
        // count * 1000 as 1024 - 16 - 8.
        cnt_x1000 = {r_cnt_i, 10'd0} - {4'd0, r_cnt_i, 6'd0} + {4'd0, r_cnt_i, 6'd0}
                  - {6'd0, r_cnt_i, 4'd0} - {7'd0, r_cnt_i, 3'd0};
    end

    // Route operands to the shared units by sequencer state.
    always_comb begin
        div_dividend = '0;
        div_divisor  = '0;
        sq_radicand  = '0;
        div_start    = 1'b0;
        sq_start     = 1'b0;
        case (r_state)
            ST_DIV_I: begin
                div_dividend = {r_sum_i, 8'd0};
                div_divisor  = r_cnt_i;
                div_start    = !r_issued;
            end
            ST_DIV_Q: begin
                div_dividend = {r_sum_q, 8'd0};
                div_divisor  = r_cnt_q;
                div_start    = !r_issued;
            end
            ST_DIV_R: begin
                div_dividend = DW'(cnt_x1000);
                div_divisor  = CB'(r_ms);
                div_start    = !r_issued;
            end
            ST_ROOT_I: begin
                sq_radicand = r_scaled_i;
                sq_start    = !r_issued;
            end
            ST_ROOT_Q: begin
                sq_radicand = r_scaled_q;
                sq_start    = !r_issued;
            end
            default: begin
            end
        endcase
    end

    iqm_divider #(.DW(DW), .VW(CB)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_quotient (div_quotient),
        .o_stat     (div_stat)
    );

    iqm_isqrt #(.XW(XW)) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sq_start),
        .i_radicand (sq_radicand),
        .o_root     (sq_root),
        .o_stat     (sq_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_window    <= WINDOW_RESET;
            r_centre    <= CENTRE_RESET;
            r_sum_i     <= '0;
            r_sum_q     <= '0;
            r_peak_i    <= '0;
            r_peak_q    <= '0;
            r_cnt_i     <= '0;
            r_cnt_q     <= '0;
            r_fail      <= '0;
            r_ms        <= '0;
            r_issued    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // The user must send configuration writes only while idle; the block does not enforce this.
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_WINDOW_MS:    r_window <= i_cfg_data;
                    REG_CENTRE_COUNT: r_centre <= i_cfg_data[RAW_BITS-1:0];
                    default: begin
                    end
                endcase
            end

            // Drop valid once taken, unless a new report loads in the same cycle.
            if (out_fire && !out_load) begin
                r_out_valid <= 1'b0;
            end

            if (div_start || sq_start) begin
                r_issued <= 1'b1;
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        if (i_in.action == ACT_TICK) begin
                            r_ms <= n_ms;
                            if (n_ms >= limit) begin
                                r_state <= ST_DIV_I;
                            end
                        end else begin
                            // Latch magnitudes; count failed readings now.
                            r_mag_i <= mag_i;
                            r_mag_q <= mag_q;
                            r_ok_i  <= i_in.i_ok;
                            r_ok_q  <= i_in.q_ok;
                            r_fail  <= r_fail + {31'd0, ~i_in.i_ok} + {31'd0, ~i_in.q_ok};
                            r_state <= ST_SQUARE;
                        end
                    end
                end
                ST_SQUARE: begin
                    r_sq_i  <= r_mag_i * r_mag_i;
                    r_sq_q  <= r_mag_q * r_mag_q;
                    r_state <= ST_ACC;
                end
                ST_ACC: begin
                    // Drop failed readings and readings of a channel whose count is saturated.
                    if (r_ok_i && (r_cnt_i != CNT_MAX)) begin
                        r_sum_i <= r_sum_i + SW'(r_sq_i);
                        r_cnt_i <= r_cnt_i + 1'b1;
                        if (r_mag_i > r_peak_i) begin
                            r_peak_i <= r_mag_i;
                        end
                    end
                    if (r_ok_q && (r_cnt_q != CNT_MAX)) begin
                        r_sum_q <= r_sum_q + SW'(r_sq_q);
                        r_cnt_q <= r_cnt_q + 1'b1;
                        if (r_mag_q > r_peak_q) begin
                            r_peak_q <= r_mag_q;
                        end
                    end
                    r_state <= ST_IDLE;
                end
                ST_DIV_I: begin
                    if (div_stat.done) begin
                        r_scaled_i <= div_quotient[XW-1:0];
                        r_issued   <= 1'b0;
                        r_state    <= ST_DIV_Q;
                    end
                end
                ST_DIV_Q: begin
                    if (div_stat.done) begin
                        r_scaled_q <= div_quotient[XW-1:0];
                        r_issued   <= 1'b0;
                        r_state    <= ST_DIV_R;
                    end
                end
                ST_DIV_R: begin
                    if (div_stat.done) begin
                        r_rate_q <= div_quotient;
                        r_issued <= 1'b0;
                        r_state  <= ST_ROOT_I;
                    end
                end
                ST_ROOT_I: begin
                    if (sq_stat.done) begin
                        r_root_i <= sq_root;
                        r_issued <= 1'b0;
                        r_state  <= ST_ROOT_Q;
                    end
                end
                ST_ROOT_Q: begin
                    if (sq_stat.done) begin
                        r_root_q <= sq_root;
                        r_issued <= 1'b0;
                        r_state  <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    // Hold until the output register frees, then load and clear the window.
                    if (out_load) begin
                        r_out_valid  <= 1'b1;
                        r_out_rms_i  <= rms_out(r_root_i, r_cnt_i);
                        r_out_rms_q  <= rms_out(r_root_q, r_cnt_q);
                        r_out_peak_i <= peak_out(r_peak_i);
                        r_out_peak_q <= peak_out(r_peak_q);
                        r_out_error  <= r_fail;
                        r_out_rate   <= (r_rate_q > DW'(33'h0_FFFF_FFFF)) ? 32'hFFFF_FFFF
                                                                        : r_rate_q[31:0];
                        r_sum_i  <= '0;
                        r_sum_q  <= '0;
                        r_peak_i <= '0;
                        r_peak_q <= '0;
                        r_cnt_i  <= '0;
                        r_cnt_q  <= '0;
                        r_ms     <= '0;
                        r_state  <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready        = (r_state == ST_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.rms_i_q4    = r_out_rms_i;
    assign o_out.peak_i      = r_out_peak_i;
    assign o_out.rms_q_q4    = r_out_rms_q;
    assign o_out.peak_q      = r_out_peak_q;
    assign o_out.error_total = r_out_error;
    assign o_out.rate_hz     = r_out_rate;

    assign div_phase  = (r_state == ST_DIV_I) || (r_state == ST_DIV_Q) || (r_state == ST_DIV_R);
    assign root_phase = (r_state == ST_ROOT_I) || (r_state == ST_ROOT_Q);
    assign peak_lone  = (r_peak_i != '0) && (r_cnt_i == '0);
    assign report_ok  = r_out_valid && (r_ms == '0) && (r_cnt_i == '0) && (r_cnt_q == '0);

    `ASSERT_CLK(a_div_done_owned, i_clk, i_rst_n, div_stat.done |-> div_phase, "stray div done")
    `ASSERT_CLK(a_sqrt_done_owned, i_clk, i_rst_n, sq_stat.done |-> root_phase, "stray root done")
    `ASSERT_NEVER(a_units_overlap, i_clk, i_rst_n, div_stat.busy && sq_stat.busy, "units overlap")
    `ASSERT_NEVER(a_peak_without_count, i_clk, i_rst_n, peak_lone, "peak set in empty window")
    `ASSERT_CLK(a_report_clears, i_clk, i_rst_n, out_load |=> report_ok, "window left open")
endmodule
